### hw/rtl/lpca_pkg.sv
// ============================================================================
// lpca_pkg : shared types and constants for the closest-approach engine
// Transaction payload structs, word format and multiplier chunk size.
// ============================================================================
`default_nettype none

package lpca_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = WORD_BITS / 2;
    // widest operand slice fed to one hardware multiplier
    localparam int MUL_CHUNK = 32;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] point_a_x;
        logic signed [WORD_BITS-1:0] point_a_y;
        logic signed [WORD_BITS-1:0] point_a_z;
        logic signed [WORD_BITS-1:0] point_b_x;
        logic signed [WORD_BITS-1:0] point_b_y;
        logic signed [WORD_BITS-1:0] point_b_z;
        logic signed [WORD_BITS-1:0] dir_a_x;
        logic signed [WORD_BITS-1:0] dir_a_y;
        logic signed [WORD_BITS-1:0] dir_a_z;
        logic signed [WORD_BITS-1:0] dir_b_x;
        logic signed [WORD_BITS-1:0] dir_b_y;
        logic signed [WORD_BITS-1:0] dir_b_z;
    } t_lines_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] param_a;
        logic signed [WORD_BITS-1:0] param_b;
        logic        [WORD_BITS-1:0] distance;
        logic                        parallel;
    } t_approach_out;

    // side info carried along the quotient stages
    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic parallel;
    } t_quot_ctl;

endpackage

`default_nettype wire

### hw/rtl/lpca_mul.sv
// ============================================================================
// lpca_mul : pipelined signed multiplier
// Sign/magnitude split, chunked partial products, row sums, final sum.
// Each register stage advances only while i_en is high.
// ============================================================================
`default_nettype none

module lpca_mul
    import lpca_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire  signed [AW-1:0]      i_a,
    input  wire  signed [BW-1:0]      i_b,
    output logic signed [AW+BW-1:0]   o_p
);

    localparam int CK  = MUL_CHUNK;
    localparam int NA  = (AW + CK - 1) / CK;
    localparam int NB  = (BW + CK - 1) / CK;
    localparam int EAW = NA * CK;
    localparam int EBW = NB * CK;
    localparam int PW  = EAW + EBW;
    localparam int OW  = AW + BW;

    logic [AW-1:0]  abs_a;
    logic [BW-1:0]  abs_b;
    logic [EAW-1:0] ext_a;
    logic [EBW-1:0] ext_b;

    assign abs_a = i_a[AW-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign abs_b = i_b[BW-1] ? $unsigned(-i_b) : $unsigned(i_b);
    assign ext_a = EAW'(abs_a);
    assign ext_b = EBW'(abs_b);

    // stage 1: partial products
    logic [2*CK-1:0] r_pp [NA][NB];
    logic            r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= ext_a[i*CK +: CK] * ext_b[j*CK +: CK];
                end
            end
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
        end
    end

    // stage 2: one sum per row of partial products
    logic [PW-1:0] n_row [NA];
    logic [PW-1:0] r_row [NA];
    logic          r_neg2;

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (CK * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row  <= n_row;
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: rows together, sign restored
    logic [PW-1:0] n_total;
    logic [OW-1:0] n_mag;
    logic [OW-1:0] r_p;

    always_comb begin
        n_total = '0;
        for (int i = 0; i < NA; i++) begin
            n_total = n_total + (r_row[i] << (CK * i));
        end
        n_mag = n_total[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg2 ? (~n_mag + OW'(1)) : n_mag;
        end
    end

    assign o_p = $signed(r_p);

endmodule

`default_nettype wire

### hw/rtl/lpca_quot_stage.sv
// ============================================================================
// lpca_quot_stage : one quotient bit for both parameters and the distance
// Restoring division step for the two parameters, integer square root step
// (against a running q*den) for the distance.
// ============================================================================
`default_nettype none

module lpca_quot_stage
    import lpca_pkg::*;
#(
    parameter int BIT  = 0,
    parameter int QW   = 32,
    parameter int DENW = 132,
    parameter int DRW  = 164,
    parameter int SRW  = 202
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire  [DENW-1:0]      i_den,
    input  wire  [DRW-1:0]       i_rem_a,
    input  wire  [DRW-1:0]       i_rem_b,
    input  wire  [SRW-1:0]       i_rem_d,
    input  wire  [DENW+QW-1:0]   i_qden,
    input  wire  [QW-1:0]        i_q_a,
    input  wire  [QW-1:0]        i_q_b,
    input  wire  [QW-1:0]        i_q_d,
    input  t_quot_ctl            i_ctl,
    output logic [DENW-1:0]      o_den,
    output logic [DRW-1:0]       o_rem_a,
    output logic [DRW-1:0]       o_rem_b,
    output logic [SRW-1:0]       o_rem_d,
    output logic [DENW+QW-1:0]   o_qden,
    output logic [QW-1:0]        o_q_a,
    output logic [QW-1:0]        o_q_b,
    output logic [QW-1:0]        o_q_d,
    output t_quot_ctl            o_ctl
);

    localparam int QDW = DENW + QW;

    logic [DRW-1:0] den_sh;
    logic           take_a;
    logic           take_b;
    logic [SRW-1:0] trial;
    logic           take_d;

    assign den_sh = DRW'(i_den) << BIT;
    assign take_a = den_sh <= i_rem_a;
    assign take_b = den_sh <= i_rem_b;

    // (q + 2^k)^2 den - q^2 den = 2^(k+1) q den + 2^(2k) den
    assign trial  = (SRW'(i_qden) << (BIT + 1)) + (SRW'(i_den) << (2 * BIT));
    assign take_d = trial <= i_rem_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den   <= i_den;
            o_ctl   <= i_ctl;
            o_rem_a <= take_a ? (i_rem_a - den_sh) : i_rem_a;
            o_rem_b <= take_b ? (i_rem_b - den_sh) : i_rem_b;
            o_q_a   <= i_q_a | (QW'(take_a) << BIT);
            o_q_b   <= i_q_b | (QW'(take_b) << BIT);
            o_rem_d <= take_d ? (i_rem_d - trial) : i_rem_d;
            o_qden  <= take_d ? (i_qden + (QDW'(i_den) << BIT)) : i_qden;
            o_q_d   <= i_q_d | (QW'(take_d) << BIT);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/line_pair_closest_approach.sv
// ============================================================================
// line_pair_closest_approach : closest approach of two 3D lines
// Fixed-point pipeline: dot/cross products, 2x2 solve by bit-serial
// division stages, distance by an integer square root in the same stages.
// ============================================================================
//
//  channel  direction  valid     stall     payload
//  -------  ---------  --------  --------  ------------------------------
//  lines    in         i_valid   o_stall   i_data  (t_lines_in)
//  result   out        o_valid   i_stall   o_data  (t_approach_out)
//
// One transaction per clock, sustained while the result is not stalled.
// Products pass capture, three multiplier groups and their combine stages,
// then one quotient stage per bit and the output register.
// Reset (synchronous, active low) clears only the valid bits.
// A stalled result freezes the whole pipe; o_stall follows it in the same
// cycle, so nothing is dropped or repeated.
// ============================================================================
`default_nettype none

module line_pair_closest_approach
    import lpca_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  t_lines_in      i_data,
    output logic           o_valid,
    input  wire            i_stall,
    output t_approach_out  o_data
);

    // ---------------------------------------------------------------
    // widths
    // ---------------------------------------------------------------
    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int WW    = W + 1;           // point difference
    localparam int CRW   = 2 * W + 1;       // cross product component
    localparam int DOTW  = 2 * W + 3;       // a, b, c, d, e
    localparam int DENW  = 4 * W + 4;       // |cross|^2
    localparam int NUMW  = 4 * W + 7;       // solve numerators
    localparam int DETSW = 3 * W + 4;       // w . cross
    localparam int DETMW = 3 * W + 5;       // |w . cross| as signed
    localparam int SQW   = 2 * DETMW;       // det^2
    localparam int XW    = NUMW + F;
    localparam int DRW   = (XW > DENW + W) ? XW : DENW + W;
    localparam int SRW   = (SQW > DENW + 2 * W + 2) ? SQW : DENW + 2 * W + 2;
    localparam int QDW   = DENW + W;
    localparam int VL    = 13 + W;          // valid bits ahead of the output reg

    // ---------------------------------------------------------------
    // flow control: one global enable
    // ---------------------------------------------------------------
    logic          en;
    logic [VL-1:0] r_vld;
    logic          r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[VL-2:0], i_valid};
            r_out_valid <= r_vld[VL-1];
        end
    end

    // ---------------------------------------------------------------
    // stage 1: capture, point difference
    // ---------------------------------------------------------------
    logic signed [W-1:0]  r1_da [3];
    logic signed [W-1:0]  r1_db [3];
    logic signed [WW-1:0] r1_w  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_da[0] <= i_data.dir_a_x;
            r1_da[1] <= i_data.dir_a_y;
            r1_da[2] <= i_data.dir_a_z;
            r1_db[0] <= i_data.dir_b_x;
            r1_db[1] <= i_data.dir_b_y;
            r1_db[2] <= i_data.dir_b_z;
            r1_w[0]  <= WW'(i_data.point_b_x) - WW'(i_data.point_a_x);
            r1_w[1]  <= WW'(i_data.point_b_y) - WW'(i_data.point_a_y);
            r1_w[2]  <= WW'(i_data.point_b_z) - WW'(i_data.point_a_z);
        end
    end

    // ---------------------------------------------------------------
    // multiplier group 1: cross terms and the five dot products
    // ---------------------------------------------------------------
    logic signed [2*W-1:0]  m_crp [3];
    logic signed [2*W-1:0]  m_crn [3];
    logic signed [2*W-1:0]  m_aa  [3];
    logic signed [2*W-1:0]  m_ab  [3];
    logic signed [2*W-1:0]  m_bb  [3];
    logic signed [2*W:0]    m_dw  [3];
    logic signed [2*W:0]    m_ew  [3];

    for (genvar k = 0; k < 3; k++) begin : g_grp1
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        lpca_mul #(.AW(W), .BW(W)) u_crp (
            .i_clk(i_clk), .i_en(en), .i_a(r1_da[K1]), .i_b(r1_db[K2]), .o_p(m_crp[k]));
        lpca_mul #(.AW(W), .BW(W)) u_crn (
            .i_clk(i_clk), .i_en(en), .i_a(r1_da[K2]), .i_b(r1_db[K1]), .o_p(m_crn[k]));
        lpca_mul #(.AW(W), .BW(W)) u_aa (
            .i_clk(i_clk), .i_en(en), .i_a(r1_da[k]), .i_b(r1_da[k]), .o_p(m_aa[k]));
        lpca_mul #(.AW(W), .BW(W)) u_ab (
            .i_clk(i_clk), .i_en(en), .i_a(r1_da[k]), .i_b(r1_db[k]), .o_p(m_ab[k]));
        lpca_mul #(.AW(W), .BW(W)) u_bb (
            .i_clk(i_clk), .i_en(en), .i_a(r1_db[k]), .i_b(r1_db[k]), .o_p(m_bb[k]));
        lpca_mul #(.AW(W), .BW(WW)) u_dw (
            .i_clk(i_clk), .i_en(en), .i_a(r1_da[k]), .i_b(r1_w[k]), .o_p(m_dw[k]));
        lpca_mul #(.AW(W), .BW(WW)) u_ew (
            .i_clk(i_clk), .i_en(en), .i_a(r1_db[k]), .i_b(r1_w[k]), .o_p(m_ew[k]));
    end

    // w waits out the multiplier latency
    logic signed [WW-1:0] r_w_dly [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w_dly[0] <= r1_w;
            r_w_dly[1] <= r_w_dly[0];
            r_w_dly[2] <= r_w_dly[1];
        end
    end

    // ---------------------------------------------------------------
    // stage 5: cross product and dot sums
    // ---------------------------------------------------------------
    logic signed [CRW-1:0]  r5_cr [3];
    logic signed [WW-1:0]   r5_w  [3];
    logic signed [DOTW-1:0] r5_a, r5_b, r5_c, r5_d, r5_e;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r5_cr[k] <= CRW'(m_crp[k]) - CRW'(m_crn[k]);
            end
            r5_w <= r_w_dly[2];
            r5_a <= DOTW'(m_aa[0]) + DOTW'(m_aa[1]) + DOTW'(m_aa[2]);
            r5_b <= DOTW'(m_ab[0]) + DOTW'(m_ab[1]) + DOTW'(m_ab[2]);
            r5_c <= DOTW'(m_bb[0]) + DOTW'(m_bb[1]) + DOTW'(m_bb[2]);
            r5_d <= DOTW'(m_dw[0]) + DOTW'(m_dw[1]) + DOTW'(m_dw[2]);
            r5_e <= DOTW'(m_ew[0]) + DOTW'(m_ew[1]) + DOTW'(m_ew[2]);
        end
    end

    // ---------------------------------------------------------------
    // multiplier group 2: |cross|^2, solve numerators, w . cross
    // ---------------------------------------------------------------
    logic signed [2*CRW-1:0]   m_sq [3];
    logic signed [WW+CRW-1:0]  m_wc [3];
    logic signed [2*DOTW-1:0]  m_cd, m_be, m_bd, m_ae;

    for (genvar k = 0; k < 3; k++) begin : g_grp2
        lpca_mul #(.AW(CRW), .BW(CRW)) u_sq (
            .i_clk(i_clk), .i_en(en), .i_a(r5_cr[k]), .i_b(r5_cr[k]), .o_p(m_sq[k]));
        lpca_mul #(.AW(WW), .BW(CRW)) u_wc (
            .i_clk(i_clk), .i_en(en), .i_a(r5_w[k]), .i_b(r5_cr[k]), .o_p(m_wc[k]));
    end

    lpca_mul #(.AW(DOTW), .BW(DOTW)) u_cd (
        .i_clk(i_clk), .i_en(en), .i_a(r5_c), .i_b(r5_d), .o_p(m_cd));
    lpca_mul #(.AW(DOTW), .BW(DOTW)) u_be (
        .i_clk(i_clk), .i_en(en), .i_a(r5_b), .i_b(r5_e), .o_p(m_be));
    lpca_mul #(.AW(DOTW), .BW(DOTW)) u_bd (
        .i_clk(i_clk), .i_en(en), .i_a(r5_b), .i_b(r5_d), .o_p(m_bd));
    lpca_mul #(.AW(DOTW), .BW(DOTW)) u_ae (
        .i_clk(i_clk), .i_en(en), .i_a(r5_a), .i_b(r5_e), .o_p(m_ae));

    // ---------------------------------------------------------------
    // stage 9: denominator, numerators, |w . cross|
    // ---------------------------------------------------------------
    logic signed [DENW-1:0]  n9_den;
    logic signed [DETSW-1:0] n9_det;
    logic signed [DENW-1:0]  r9_den;
    logic signed [NUMW-1:0]  r9_ns, r9_nt;
    logic signed [DETMW-1:0] r9_det;
    logic                    r9_par;

    assign n9_den = DENW'(m_sq[0]) + DENW'(m_sq[1]) + DENW'(m_sq[2]);
    assign n9_det = DETSW'(m_wc[0]) + DETSW'(m_wc[1]) + DETSW'(m_wc[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_den <= n9_den;
            r9_par <= (n9_den == '0);
            r9_ns  <= NUMW'(m_cd) - NUMW'(m_be);
            r9_nt  <= NUMW'(m_bd) - NUMW'(m_ae);
            r9_det <= n9_det[DETSW-1] ? -DETMW'(n9_det) : DETMW'(n9_det);
        end
    end

    // multiplier group 3: det^2
    logic signed [SQW-1:0] m_det2;

    lpca_mul #(.AW(DETMW), .BW(DETMW)) u_det2 (
        .i_clk(i_clk), .i_en(en), .i_a(r9_det), .i_b(r9_det), .o_p(m_det2));

    logic signed [DENW-1:0] r_den_dly [3];
    logic signed [NUMW-1:0] r_ns_dly  [3];
    logic signed [NUMW-1:0] r_nt_dly  [3];
    logic                   r_par_dly [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den_dly[0] <= r9_den;
            r_ns_dly[0]  <= r9_ns;
            r_nt_dly[0]  <= r9_nt;
            r_par_dly[0] <= r9_par;
            for (int k = 1; k < 3; k++) begin
                r_den_dly[k] <= r_den_dly[k-1];
                r_ns_dly[k]  <= r_ns_dly[k-1];
                r_nt_dly[k]  <= r_nt_dly[k-1];
                r_par_dly[k] <= r_par_dly[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 13: quotient operands (magnitudes scaled by 2^F)
    // ---------------------------------------------------------------
    logic [NUMW-1:0] n13_mag_a, n13_mag_b;

    assign n13_mag_a = r_ns_dly[2][NUMW-1] ? $unsigned(-r_ns_dly[2]) : $unsigned(r_ns_dly[2]);
    assign n13_mag_b = r_nt_dly[2][NUMW-1] ? $unsigned(-r_nt_dly[2]) : $unsigned(r_nt_dly[2]);

    logic [DENW-1:0] c_den   [W+1];
    logic [DRW-1:0]  c_rem_a [W+1];
    logic [DRW-1:0]  c_rem_b [W+1];
    logic [SRW-1:0]  c_rem_d [W+1];
    logic [QDW-1:0]  c_qden  [W+1];
    logic [W-1:0]    c_q_a   [W+1];
    logic [W-1:0]    c_q_b   [W+1];
    logic [W-1:0]    c_q_d   [W+1];
    t_quot_ctl       c_ctl   [W+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_den[0]          <= $unsigned(r_den_dly[2]);
            c_rem_a[0]        <= DRW'(n13_mag_a) << F;
            c_rem_b[0]        <= DRW'(n13_mag_b) << F;
            c_rem_d[0]        <= SRW'($unsigned(m_det2));
            c_qden[0]         <= '0;
            c_q_a[0]          <= '0;
            c_q_b[0]          <= '0;
            c_q_d[0]          <= '0;
            c_ctl[0].neg_a    <= r_ns_dly[2][NUMW-1];
            c_ctl[0].neg_b    <= r_nt_dly[2][NUMW-1];
            c_ctl[0].parallel <= r_par_dly[2];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < W; s++) begin : g_quot
        lpca_quot_stage #(
            .BIT(W - 1 - s), .QW(W), .DENW(DENW), .DRW(DRW), .SRW(SRW)
        ) u_stage (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_den  (c_den[s]),
            .i_rem_a(c_rem_a[s]),
            .i_rem_b(c_rem_b[s]),
            .i_rem_d(c_rem_d[s]),
            .i_qden (c_qden[s]),
            .i_q_a  (c_q_a[s]),
            .i_q_b  (c_q_b[s]),
            .i_q_d  (c_q_d[s]),
            .i_ctl  (c_ctl[s]),
            .o_den  (c_den[s+1]),
            .o_rem_a(c_rem_a[s+1]),
            .o_rem_b(c_rem_b[s+1]),
            .o_rem_d(c_rem_d[s+1]),
            .o_qden (c_qden[s+1]),
            .o_q_a  (c_q_a[s+1]),
            .o_q_b  (c_q_b[s+1]),
            .o_q_d  (c_q_d[s+1]),
            .o_ctl  (c_ctl[s+1])
        );
    end

    // ---------------------------------------------------------------
    // output register: sign, saturation, parallel case forced to zero
    // ---------------------------------------------------------------
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_param(input logic [W-1:0] q, input logic neg);
        logic [W-1:0] lim;
        begin
            if (neg) begin
                lim = (q > HALF) ? HALF : q;
                return ~lim + W'(1);
            end
            return (q > HALF - W'(1)) ? (HALF - W'(1)) : q;
        end
    endfunction

    t_quot_ctl     last_ctl;
    t_approach_out n_out;
    t_approach_out r_out;

    assign last_ctl = c_ctl[W];

    always_comb begin
        if (last_ctl.parallel) begin
            n_out          = '0;
            n_out.parallel = 1'b1;
        end else begin
            n_out.param_a  = $signed(sat_param(c_q_a[W], last_ctl.neg_a));
            n_out.param_b  = $signed(sat_param(c_q_b[W], last_ctl.neg_b));
            n_out.distance = c_q_d[W];
            n_out.parallel = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.parallel |->
            o_data.param_a == '0 && o_data.param_b == '0 && o_data.distance == '0)
        else $error("parallel result carries nonzero fields");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted transaction did not enter the pipe");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipe moved while frozen");

endmodule

`default_nettype wire
